[hdl/brr_adpcm_block_decoder_top_assert.svh]
// ----------------------------------------------------------------------------
// brr decoder assertion macros
// shared property wrappers, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef BRR_ADPCM_BLOCK_DECODER_TOP_ASSERT_SVH
`define BRR_ADPCM_BLOCK_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define BRR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/brr_pkg.sv]
// ----------------------------------------------------------------------------
// brr decoder package
// widths, filter coefficients and the arithmetic unit control group
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 10;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int PSH_W          = PROD_W - 9;
    localparam int ACC_W          = 19;
    localparam int DATA_BYTES_DEF = 8;
    localparam logic [3:0] RANGE_MAX = 4'd12;
    localparam logic [3:0] RANGE_ADJ = 4'd4;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(32768);

    typedef struct packed {
        logic mul_en;     // capture a product
        logic sel_older;  // multiply the older sample with the second coefficient
        logic acc_load;   // acc = scaled nibble + product
        logic acc_add;    // acc = acc + product
    } mac_ctrl_t;

    // prediction coefficients in 1/256 units
    function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] filt,
                                                       input logic second);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case ({filt, second})
            3'b010:  c = COEF_W'(240);
            3'b100:  c = COEF_W'(488);
            3'b101:  c = -COEF_W'(240);
            3'b110:  c = COEF_W'(460);
            3'b111:  c = -COEF_W'(208);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hdl/brr_mac_unit.sv]
// ----------------------------------------------------------------------------
// brr shared multiply-accumulate unit
// one multiplier used twice per sample, accumulator, clamp and doubling
// ----------------------------------------------------------------------------
module brr_mac_unit
(
    input  logic                                    clk,
    input  brr_pkg::mac_ctrl_t                      ctrl,
    input  logic [3:0]                              nibble,
    input  logic [3:0]                              shift_range,
    input  logic [1:0]                              filter_select,
    input  logic signed [brr_pkg::SAMPLE_W-1:0]     newer,
    input  logic signed [brr_pkg::SAMPLE_W-1:0]     older,
    output logic signed [brr_pkg::SAMPLE_W-1:0]     result
);

    logic signed [brr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [brr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [brr_pkg::ACC_W-1:0]    acc_next;
    logic signed [brr_pkg::SAMPLE_W-1:0] op_sample;
    logic signed [brr_pkg::COEF_W-1:0]   op_coef;
    logic signed [brr_pkg::PSH_W-1:0]    prod_sh;
    logic signed [16:0]                  nib_ext;
    logic signed [16:0]                  nib_shl;
    logic signed [brr_pkg::SAMPLE_W-1:0] scaled;
    logic signed [brr_pkg::SAMPLE_W-1:0] clamped;

    assign op_sample = ctrl.sel_older ? older : newer;
    assign op_coef   = brr_pkg::coef(filter_select, ctrl.sel_older);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_sample * op_coef;
        end
        acc_reg <= acc_next;
    end

    // floor shift by 9 is a plain slice of the signed product
    assign prod_sh = prod_reg[brr_pkg::PROD_W-1:9];

    assign nib_ext = 17'(signed'(nibble));
    assign nib_shl = nib_ext <<< shift_range;
    assign scaled  = nib_shl[16:1];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_load)
        begin
            acc_next = brr_pkg::ACC_W'(scaled) + brr_pkg::ACC_W'(prod_sh);
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + brr_pkg::ACC_W'(prod_sh);
        end
    end

    always_comb
    begin
        if (acc_reg > brr_pkg::ACC_MAX)
        begin
            clamped = 16'sh7fff;
        end
        else if (acc_reg < brr_pkg::ACC_MIN)
        begin
            clamped = -16'sh8000;
        end
        else
        begin
            clamped = acc_reg[15:0];
        end
    end

    // doubling drops the top bit, so the result wraps
    assign result = {clamped[14:0], 1'b0};

endmodule

[hdl/brr_adpcm_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// brr adpcm block decoder
// decodes a header byte plus data bytes into 16-bit samples, two per byte
// ----------------------------------------------------------------------------
// A header transfer yields nothing; it sets range, filter and end/loop flags
// and loads both history samples. A data byte transfer yields two samples,
// upper nibble first, and the input is not ready again until both are
// written: each sample passes the one shared multiplier in turn (newer
// product, older product, final add, clamp and write out), and the final
// write also waits while the output side stalls. Samples leave through an
// output register, so a header can be taken while the last sample still
// waits. tlast marks the last sample of each block of DATA_BYTES data bytes;
// extra data bytes start a new block with the same header settings and the
// running history.
module brr_adpcm_block_decoder_top
#(
    parameter int DATA_BYTES = brr_pkg::DATA_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_byte[7:0], history_newer[23:8], history_older[39:24]
    input  logic [0:0]  s_axis_tuser,  // is_header[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // sample[15:0]
    output logic [2:0]  m_axis_tuser,  // pair_last[0], end_loop_bits[2:1]
    output logic        m_axis_tlast   // block_last
);

    localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_BYTES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD0 = 3'd1;
    localparam logic [2:0] ST_PROD1 = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [3:0]                          range_reg, range_next;
    logic [1:0]                          filter_reg, filter_next;
    logic [1:0]                          flags_reg, flags_next;
    logic signed [brr_pkg::SAMPLE_W-1:0] newer_reg, newer_next;
    logic signed [brr_pkg::SAMPLE_W-1:0] older_reg, older_next;
    logic [IDX_W-1:0]                    index_reg, index_next;
    logic                                half_reg, half_next;
    logic [7:0]                          byte_reg, byte_next;

    logic                                out_valid_reg, out_valid_next;
    logic signed [brr_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                out_pair_reg;
    logic                                out_last_reg;
    logic [1:0]                          out_flags_reg;

    logic                                in_xfer;
    logic                                write_go;
    logic                                at_last;
    logic [3:0]                          hdr_range;
    logic [3:0]                          nibble;
    logic signed [brr_pkg::SAMPLE_W-1:0] mac_result;
    brr_pkg::mac_ctrl_t                  mac_ctrl;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign write_go      = (state_reg == ST_WRITE) && (!out_valid_reg || m_axis_tready);
    assign at_last       = (index_reg == IDX_LAST);
    assign nibble        = half_reg ? byte_reg[3:0] : byte_reg[7:4];

    // ranges 13 to 15 act as 9 to 11
    assign hdr_range = (s_axis_tdata[7:4] > brr_pkg::RANGE_MAX) ?
                       (s_axis_tdata[7:4] - brr_pkg::RANGE_ADJ) : s_axis_tdata[7:4];

    always_comb
    begin
        mac_ctrl = '0;
        case (state_reg)
            ST_PROD0:
            begin
                mac_ctrl.mul_en = 1'b1;
            end
            ST_PROD1:
            begin
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.sel_older = 1'b1;
                mac_ctrl.acc_load  = 1'b1;
            end
            ST_ADD:
            begin
                mac_ctrl.acc_add = 1'b1;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        range_next  = range_reg;
        filter_next = filter_reg;
        flags_next  = flags_reg;
        newer_next  = newer_reg;
        older_next  = older_reg;
        index_next  = index_reg;
        half_next   = half_reg;
        byte_next   = byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0])
                    begin
                        range_next  = hdr_range;
                        filter_next = s_axis_tdata[3:2];
                        flags_next  = s_axis_tdata[1:0];
                        newer_next  = s_axis_tdata[23:8];
                        older_next  = s_axis_tdata[39:24];
                        index_next  = '0;
                    end
                    else
                    begin
                        byte_next  = s_axis_tdata[7:0];
                        half_next  = 1'b0;
                        state_next = ST_PROD0;
                    end
                end
            end
            ST_PROD0:
            begin
                state_next = ST_PROD1;
            end
            ST_PROD1:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (write_go)
                begin
                    older_next = newer_reg;
                    newer_next = mac_result;
                    if (!half_reg)
                    begin
                        half_next  = 1'b1;
                        state_next = ST_PROD0;
                    end
                    else
                    begin
                        half_next  = 1'b0;
                        index_next = at_last ? '0 : index_reg + IDX_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (write_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_reg     <= '0;
            filter_reg    <= '0;
            flags_reg     <= '0;
            newer_reg     <= '0;
            older_reg     <= '0;
            index_reg     <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            range_reg     <= range_next;
            filter_reg    <= filter_next;
            flags_reg     <= flags_next;
            newer_reg     <= newer_next;
            older_reg     <= older_next;
            index_reg     <= index_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (write_go)
        begin
            out_sample_reg <= mac_result;
            out_pair_reg   <= half_reg;
            out_last_reg   <= half_reg && at_last;
            out_flags_reg  <= flags_reg;
        end
    end

    brr_mac_unit u_mac
    (
        .clk           (clk),
        .ctrl          (mac_ctrl),
        .nibble        (nibble),
        .shift_range   (range_reg),
        .filter_select (filter_reg),
        .newer         (newer_reg),
        .older         (older_reg),
        .result        (mac_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = {out_flags_reg, out_pair_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[hdl/brr_checker.sv]
// ----------------------------------------------------------------------------
// brr decoder port checker
// port-level properties of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "brr_adpcm_block_decoder_top_assert.svh"

module brr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled sample holds its value
    `BRR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")

    // block end only on the second sample of a byte
    `BRR_ASSERT_IMP(a_last_pair, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "tlast on first sample of a byte")

    // a data byte transfer starts decoding, input closes
    `BRR_ASSERT_NXT(a_data_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !s_axis_tready, "ready after data transfer")

    // a header transfer yields no work, input stays open
    `BRR_ASSERT_NXT(a_hdr_open, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], s_axis_tready, "not ready after header transfer")

endmodule

bind brr_adpcm_block_decoder_top brr_checker u_brr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
